// ===== design/mtdm_pkg.sv =====
// Shared types and constants of the multi-slot timeout manager.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`default_nettype none

package mtdm_pkg;

  // Default number of timeout slots.
  localparam int unsigned MtdmNumSlots = 8;

  // Field widths fixed by the item format.
  localparam int unsigned OpW   = 3;
  localparam int unsigned SlotW = 3;
  localparam int unsigned ValW  = 32;

  // Operation codes.
  localparam logic [OpW-1:0] OpSetReload = 3'd0;
  localparam logic [OpW-1:0] OpStart     = 3'd1;
  localparam logic [OpW-1:0] OpStop      = 3'd2;
  localparam logic [OpW-1:0] OpElapse    = 3'd3;
  localparam logic [OpW-1:0] OpRead      = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted input item
    logic wr_reload;   // write the reload value of the addressed slot
    logic wr_zero;     // clear the count of the addressed slot
    logic rd_slot;     // read count and reload of the addressed slot
    logic load_count;  // copy the reload value read into the count
    logic walk_begin;  // reset the slot walk and read slot zero
    logic walk_en;     // evaluate the current slot of the walk
    logic final_en;    // deliver the final result of the item
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OpW-1:0] op;         // operation of the item in hand
    logic           step_done;  // the current walk step can complete
    logic           walk_last;  // the walk is at its last slot
    logic           out_free;   // the output register can take a result
  } sts_t;

endpackage : mtdm_pkg

`default_nettype wire

// ===== design/mtdm_ctrl.sv =====
// Controller state machine of the multi-slot timeout manager.
// Depends on mtdm_pkg for the command and status structs and the operation codes.
`default_nettype none

module mtdm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mtdm_pkg::sts_t sts_i,
  output mtdm_pkg::cmd_t cmd_o
);
  import mtdm_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDisp  = 3'd1;
  localparam logic [2:0] SLoad  = 3'd2;
  localparam logic [2:0] SWalk  = 3'd3;
  localparam logic [2:0] SFinal = 3'd4;

  logic [2:0] state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = SDisp;
        end
      end
      SDisp: begin
        unique case (sts_i.op)
          OpSetReload: begin
            cmd_o.wr_reload = 1'b1;
            state_d         = SFinal;
          end
          OpStop: begin
            cmd_o.wr_zero = 1'b1;
            state_d       = SFinal;
          end
          OpRead: begin
            cmd_o.rd_slot = 1'b1;
            state_d       = SFinal;
          end
          OpStart: begin
            cmd_o.rd_slot = 1'b1;
            state_d       = SLoad;
          end
          OpElapse: begin
            cmd_o.walk_begin = 1'b1;
            state_d          = SWalk;
          end
          default: begin
            state_d = SFinal;
          end
        endcase
      end
      SLoad: begin
        cmd_o.load_count = 1'b1;
        cmd_o.walk_begin = 1'b1;
        state_d          = SWalk;
      end
      SWalk: begin
        cmd_o.walk_en = 1'b1;
        if (sts_i.step_done && sts_i.walk_last) begin
          state_d = SFinal;
        end
      end
      SFinal: begin
        cmd_o.final_en = 1'b1;
        if (sts_i.out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule : mtdm_ctrl

`default_nettype wire

// ===== design/mtdm_datapath.sv =====
// Datapath of the multi-slot timeout manager: slot memories, walk counter,
// minimum search, armed interval and output register. Depends on mtdm_pkg.
`default_nettype none

module mtdm_datapath #(
  parameter int unsigned NumSlots = mtdm_pkg::MtdmNumSlots
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mtdm_pkg::cmd_t              cmd_i,
  output mtdm_pkg::sts_t              sts_o,
  input  logic [mtdm_pkg::OpW-1:0]    operation_i,
  input  logic [mtdm_pkg::SlotW-1:0]  slot_i,
  input  logic [mtdm_pkg::ValW-1:0]   value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        expired_o,
  output logic [mtdm_pkg::SlotW-1:0]  slot_out_o,
  output logic [mtdm_pkg::ValW-1:0]   count_value_o,
  output logic [mtdm_pkg::ValW-1:0]   next_interval_o,
  output logic                        arm_o,
  output logic                        last_o
);
  import mtdm_pkg::*;

  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumSlots - 1);

  // Item in hand.
  logic [OpW-1:0]   op_q;
  logic [SlotW-1:0] slot_q;
  logic [ValW-1:0]  value_q;
  logic             slot_ok;
  logic [IdxW-1:0]  slot_addr;

  // Slot memories, valid bits and registered read data.
  logic [ValW-1:0]     cnt_mem [NumSlots];
  logic [ValW-1:0]     rl_mem  [NumSlots];
  logic [NumSlots-1:0] cnt_vld_q, rl_vld_q;
  logic [ValW-1:0]     cnt_rd_q, rl_rd_q;
  logic                cnt_rv_q, rl_rv_q;
  logic                cnt_we, cnt_re, rl_we, rl_re;
  logic [IdxW-1:0]     cnt_waddr, cnt_raddr;
  logic [ValW-1:0]     cnt_wdata;
  logic                cnt_fwd;

  // Walk and search state.
  logic [IdxW-1:0] idx_q;
  logic [ValW-1:0] best_q, armed_q;
  logic            have_q;
  logic [ValW-1:0] cur_cnt, rl_eff, new_cnt;
  logic            is_elapse, is_search, above, expire, stall, step_go, walk_last;

  // Output register.
  logic             out_valid_q, out_free, load_exp, load_fin;
  logic             expired_q, arm_q, last_q;
  logic [SlotW-1:0] slot_out_q;
  logic [ValW-1:0]  count_q, next_q;

  assign slot_ok   = 32'(slot_q) < NumSlots;
  assign slot_addr = IdxW'(slot_q);

  // Capture of the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      slot_q  <= slot_i;
      value_q <= value_i;
    end
  end

  // Evaluation of the slot under the walk.
  assign cur_cnt   = cnt_rv_q ? cnt_rd_q : '0;
  assign rl_eff    = rl_rv_q ? rl_rd_q : '0;
  assign is_elapse = (op_q == OpElapse);
  assign is_search = (op_q == OpElapse) || (op_q == OpStart);
  assign above     = cur_cnt > armed_q;
  assign expire    = is_elapse && (cur_cnt != '0) && !above;
  assign new_cnt   = !is_elapse ? cur_cnt : (above ? cur_cnt - armed_q : '0);
  assign out_free  = !out_valid_q || out_ready_i;
  assign stall     = expire && !out_free;
  assign step_go   = cmd_i.walk_en && !stall;
  assign walk_last = (idx_q == LastIdx);

  // Port control of the count memory.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = '0;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = '0;
    if (cmd_i.wr_zero && slot_ok) begin
      cnt_we    = 1'b1;
      cnt_waddr = slot_addr;
    end
    if (cmd_i.load_count && slot_ok) begin
      cnt_we    = 1'b1;
      cnt_waddr = slot_addr;
      cnt_wdata = rl_eff;
    end
    if (cmd_i.rd_slot && slot_ok) begin
      cnt_re    = 1'b1;
      cnt_raddr = slot_addr;
    end
    if (cmd_i.walk_begin) begin
      cnt_re    = 1'b1;
      cnt_raddr = '0;
    end
    if (step_go) begin
      if (is_elapse) begin
        cnt_we    = 1'b1;
        cnt_waddr = idx_q;
        cnt_wdata = new_cnt;
      end
      if (!walk_last) begin
        cnt_re    = 1'b1;
        cnt_raddr = idx_q + 1'b1;
      end
    end
  end

  assign cnt_fwd = cnt_we && (cnt_waddr == cnt_raddr);
  assign rl_we   = cmd_i.wr_reload && slot_ok;
  assign rl_re   = cmd_i.rd_slot && slot_ok;

  // Count memory with write-to-read forwarding.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_fwd ? cnt_wdata : cnt_mem[cnt_raddr];
    end
  end

  // Reload memory.
  always_ff @(posedge clk_i) begin
    if (rl_we) begin
      rl_mem[slot_addr] <= value_q;
    end
    if (rl_re) begin
      rl_rd_q <= rl_mem[slot_addr];
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rl_vld_q  <= '0;
      cnt_rv_q  <= 1'b0;
      rl_rv_q   <= 1'b0;
    end else begin
      if (cnt_we) begin
        cnt_vld_q[cnt_waddr] <= 1'b1;
      end
      if (rl_we) begin
        rl_vld_q[slot_addr] <= 1'b1;
      end
      if (cnt_re) begin
        cnt_rv_q <= cnt_fwd ? 1'b1 : cnt_vld_q[cnt_raddr];
      end
      if (rl_re) begin
        rl_rv_q <= rl_vld_q[slot_addr];
      end
    end
  end

  // Walk counter and running minimum of the nonzero counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      have_q <= 1'b0;
      best_q <= '0;
    end else if (cmd_i.walk_begin) begin
      idx_q  <= '0;
      have_q <= 1'b0;
      best_q <= '0;
    end else if (step_go) begin
      if (!walk_last) begin
        idx_q <= idx_q + 1'b1;
      end
      if ((new_cnt != '0) && (!have_q || (new_cnt < best_q))) begin
        best_q <= new_cnt;
        have_q <= 1'b1;
      end
    end
  end

  assign load_exp = step_go && expire;
  assign load_fin = cmd_i.final_en && out_free;

  // Armed interval, taken over when the search found an active slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else if (load_fin && is_search && have_q) begin
      armed_q <= best_q;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_exp || load_fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload: an expiry report or the final result.
  always_ff @(posedge clk_i) begin
    if (load_exp) begin
      expired_q  <= 1'b1;
      slot_out_q <= SlotW'(idx_q);
      count_q    <= '0;
      next_q     <= '0;
      arm_q      <= 1'b0;
      last_q     <= 1'b0;
    end else if (load_fin) begin
      expired_q  <= 1'b0;
      slot_out_q <= is_elapse ? '0 : slot_q;
      count_q    <= ((op_q == OpRead) && slot_ok) ? cur_cnt : '0;
      next_q     <= is_search ? best_q : '0;
      arm_q      <= is_search && have_q;
      last_q     <= 1'b1;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.step_done = !stall;
  assign sts_o.walk_last = walk_last;
  assign sts_o.out_free  = out_free;

  assign out_valid_o     = out_valid_q;
  assign expired_o       = expired_q;
  assign slot_out_o      = slot_out_q;
  assign count_value_o   = count_q;
  assign next_interval_o = next_q;
  assign arm_o           = arm_q;
  assign last_o          = last_q;

endmodule : mtdm_datapath

`default_nettype wire

// ===== design/multi_timeout_delta_manager_unit.sv =====
// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+----------
// input     | in_valid_i, in_ready_o, operation_i,      | in
//           | slot_i, value_i                           |
// result    | out_valid_o, out_ready_i, expired_o,      | out
//           | slot_out_o, count_value_o,                |
//           | next_interval_o, arm_o, last_o            |
//
// One item is handled at a time. Set reload, stop, read and unknown codes go
// from dispatch straight to the final result. Elapse walks every slot over the
// single read port of the count memory; start first loads the count, then walks.
// An expiry report or the final result waits while the output register is full.
// Reset clears the armed interval; counts and reload values read as zero through
// valid bits until they are written.
//
// Top level of the multi-slot timeout manager; depends on mtdm_pkg,
// mtdm_ctrl and mtdm_datapath.
`default_nettype none

module multi_timeout_delta_manager_unit #(
  parameter int unsigned NUM_SLOTS = mtdm_pkg::MtdmNumSlots
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mtdm_pkg::OpW-1:0]    operation_i,
  input  logic [mtdm_pkg::SlotW-1:0]  slot_i,
  input  logic [mtdm_pkg::ValW-1:0]   value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        expired_o,
  output logic [mtdm_pkg::SlotW-1:0]  slot_out_o,
  output logic [mtdm_pkg::ValW-1:0]   count_value_o,
  output logic [mtdm_pkg::ValW-1:0]   next_interval_o,
  output logic                        arm_o,
  output logic                        last_o
);
  import mtdm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each operation.
  mtdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, arithmetic and result register.
  mtdm_datapath #(
    .NumSlots (NUM_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .slot_i          (slot_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .expired_o       (expired_o),
    .slot_out_o      (slot_out_o),
    .count_value_o   (count_value_o),
    .next_interval_o (next_interval_o),
    .arm_o           (arm_o),
    .last_o          (last_o)
  );

endmodule : multi_timeout_delta_manager_unit

`default_nettype wire

// ===== design/mtdm_checker.sv =====
// Port-level checker of the multi-slot timeout manager, bound to the top level.
// Depends on mtdm_pkg for the field widths.
`default_nettype none

module mtdm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        expired_o,
  input logic [mtdm_pkg::SlotW-1:0]  slot_out_o,
  input logic [mtdm_pkg::ValW-1:0]   count_value_o,
  input logic [mtdm_pkg::ValW-1:0]   next_interval_o,
  input logic                        arm_o,
  input logic                        last_o
);
  import mtdm_pkg::*;

  // An expiry report is never the final result and carries no interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expired_o |-> !last_o && !arm_o && (next_interval_o == '0)
      && (count_value_o == '0))
    else $error("expiry report carries final-result fields");

  // An armed interval is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arm_o |-> (next_interval_o != '0))
    else $error("armed with a zero interval");

  // Every result is either an expiry report or the final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (expired_o != last_o))
    else $error("result is neither expiry nor final");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_out_o)
      && $stable(last_o) && $stable(next_interval_o))
    else $error("stalled result changed");

endmodule : mtdm_checker

bind multi_timeout_delta_manager_unit mtdm_checker u_mtdm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .expired_o       (expired_o),
  .slot_out_o      (slot_out_o),
  .count_value_o   (count_value_o),
  .next_interval_o (next_interval_o),
  .arm_o           (arm_o),
  .last_o          (last_o)
);

`default_nettype wire

// ===== verif/mtdm_timeout_checker.sv =====
// Checker for the multi-slot timeout manager: it keeps its own copy of the slot
// counts, reload values and armed interval, predicts each result and compares.
// Depends on mtdm_pkg for the field widths and the operation codes.
module mtdm_timeout_checker #(
  parameter int unsigned NUM_SLOTS = mtdm_pkg::MtdmNumSlots
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [mtdm_pkg::OpW-1:0]    operation_i,
  input  logic [mtdm_pkg::SlotW-1:0]  slot_i,
  input  logic [mtdm_pkg::ValW-1:0]   value_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        expired_i,
  input  logic [mtdm_pkg::SlotW-1:0]  slot_out_i,
  input  logic [mtdm_pkg::ValW-1:0]   count_value_i,
  input  logic [mtdm_pkg::ValW-1:0]   next_interval_i,
  input  logic                        arm_i,
  input  logic                        last_i,
  output int unsigned                 error_count_o,
  output int unsigned                 outstanding_o
);
  import mtdm_pkg::*;

  // Beyond this many mismatches the lines are no longer printed, only counted.
  localparam int unsigned PrintCap = 200;

  typedef struct packed {
    logic             expired;
    logic [SlotW-1:0] slot;
    logic [ValW-1:0]  count;
    logic [ValW-1:0]  next_ivl;
    logic             arm;
    logic             last;
  } timeout_result_t;

  // Shadow state of the timer list.
  logic [ValW-1:0] slot_count [NUM_SLOTS];
  logic [ValW-1:0] reload_val [NUM_SLOTS];
  logic [ValW-1:0] armed_ivl;

  timeout_result_t expected_results_q[$];
  timeout_result_t oldest;
  int unsigned     mismatch_total;

  task automatic report_mismatch(input string msg);
    if (mismatch_total < PrintCap) begin
      $display("[%0t] timeout result mismatch: %s", $realtime, msg);
    end
    mismatch_total++;
  endtask

  task automatic check_field(input string name, input logic [ValW-1:0] got,
                             input logic [ValW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Smallest nonzero count; the return value tells whether any slot is active.
  function automatic logic find_smallest_count(output logic [ValW-1:0] smallest);
    logic        found;
    int unsigned i;
    found    = 1'b0;
    smallest = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (slot_count[i] != '0 && (!found || slot_count[i] < smallest)) begin
        smallest = slot_count[i];
        found    = 1'b1;
      end
    end
    return found;
  endfunction

  // Apply one accepted item to the shadow state and queue the results it causes.
  task automatic predict_timeout_op(input logic [OpW-1:0] op, input logic [SlotW-1:0] slot,
                                    input logic [ValW-1:0] value);
    timeout_result_t fin;
    timeout_result_t expiry;
    logic            present;
    logic            found;
    logic [ValW-1:0] smallest;
    int unsigned     i;
    fin      = '0;
    fin.slot = slot;
    fin.last = 1'b1;
    present  = (slot < NUM_SLOTS);
    case (op)
      OpSetReload: begin
        if (present) reload_val[slot] = value;
      end
      OpStart: begin
        if (present) slot_count[slot] = reload_val[slot];
        found        = find_smallest_count(smallest);
        fin.next_ivl = smallest;
        if (found) begin
          armed_ivl = smallest;
          fin.arm   = 1'b1;
        end
      end
      OpStop: begin
        if (present) slot_count[slot] = '0;
      end
      OpElapse: begin
        fin.slot = '0;
        // Counts not beyond the armed interval expire, in ascending slot order.
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_count[i] != '0) begin
            if (slot_count[i] > armed_ivl) begin
              slot_count[i] = slot_count[i] - armed_ivl;
            end else begin
              slot_count[i]  = '0;
              expiry         = '0;
              expiry.expired = 1'b1;
              expiry.slot    = i[SlotW-1:0];
              expected_results_q.push_back(expiry);
            end
          end
        end
        found        = find_smallest_count(smallest);
        fin.next_ivl = smallest;
        if (found) begin
          armed_ivl = smallest;
          fin.arm   = 1'b1;
        end
      end
      OpRead: begin
        if (present) fin.count = slot_count[slot];
      end
      default: begin
      end
    endcase
    expected_results_q.push_back(fin);
  endtask

  // Results are checked before the item of the same edge is predicted; a result
  // can never belong to an item accepted at that very edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned j = 0; j < NUM_SLOTS; j++) begin
        slot_count[j] = '0;
        reload_val[j] = '0;
      end
      armed_ivl      = '0;
      mismatch_total = 0;
      expected_results_q.delete();
      error_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("result transfer with no result expected");
        end else begin
          oldest = expected_results_q.pop_front();
          check_field("expired", ValW'(expired_i), ValW'(oldest.expired));
          check_field("slot_out", ValW'(slot_out_i), ValW'(oldest.slot));
          check_field("count_value", count_value_i, oldest.count);
          check_field("next_interval", next_interval_i, oldest.next_ivl);
          check_field("arm", ValW'(arm_i), ValW'(oldest.arm));
          check_field("last", ValW'(last_i), ValW'(oldest.last));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_timeout_op(operation_i, slot_i, value_i);
      end
      error_count_o <= mismatch_total;
      outstanding_o <= expected_results_q.size();
    end
  end

endmodule

// ===== verif/multi_timeout_delta_manager_unit_tb.sv =====
// Testbench top of the multi-slot timeout manager: directed and random timer
// traffic under varying idling and back-pressure, checked by mtdm_timeout_checker.
// Depends on mtdm_pkg, mtdm_timeout_checker and multi_timeout_delta_manager_unit.
module multi_timeout_delta_manager_unit_tb;
  import mtdm_pkg::*;

  localparam int unsigned RunLimit    = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned MaxGap      = 12;
  localparam int unsigned PhaseItems  = 55;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic [OpW-1:0]   operation  = '0;
  logic [SlotW-1:0] slot       = '0;
  logic [ValW-1:0]  value      = '0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic             expired;
  logic [SlotW-1:0] slot_out;
  logic [ValW-1:0]  count_value;
  logic [ValW-1:0]  next_interval;
  logic             arm;
  logic             last;

  int unsigned error_count;
  int unsigned outstanding;
  int unsigned items_sent   = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned cycle_count  = 0;
  int unsigned rx_hold_cnt  = 0;
  logic        rx_hold_go   = 1'b0;
  logic        rx_hold_seen = 1'b0;

  multi_timeout_delta_manager_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .slot_i          (slot),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .expired_o       (expired),
    .slot_out_o      (slot_out),
    .count_value_o   (count_value),
    .next_interval_o (next_interval),
    .arm_o           (arm),
    .last_o          (last)
  );

  mtdm_timeout_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .operation_i     (operation),
    .slot_i          (slot),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .expired_i       (expired),
    .slot_out_i      (slot_out),
    .count_value_i   (count_value),
    .next_interval_i (next_interval),
    .arm_i           (arm),
    .last_i          (last),
    .error_count_o   (error_count),
    .outstanding_o   (outstanding)
  );

  always #1 clk = ~clk;

  // Run limit; a hang or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RunLimit) begin
      $display("multi_timeout_delta_manager_unit_tb: errors");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off when the stimulus asks for it.
  always @(posedge clk) begin
    if (rx_hold_go && !rx_hold_seen) begin
      rx_hold_seen <= 1'b1;
      rx_hold_cnt  <= HoldCycles;
      out_ready    <= 1'b0;
    end else if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Offer one item, after a random gap, and return at the edge of its transfer.
  task automatic send_item(input logic [OpW-1:0] op, input logic [SlotW-1:0] sl,
                           input logic [ValW-1:0] val);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    slot      <= sl;
    value     <= val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Hold the input side until the checker has no result outstanding.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Tick counts: mostly short so that slots expire within a few elapses.
  function automatic logic [ValW-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      3:       return $urandom_range(1000, 100000);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // A well-formed burst: load and start a few slots, then let time elapse.
  task automatic run_timer_burst();
    int unsigned     k;
    logic [ValW-1:0] ticks;
    if ($urandom_range(0, 5) == 0) begin
      // Every slot with the same count, so one elapse expires them all.
      ticks = $urandom_range(1, 20);
      for (k = 0; k < MtdmNumSlots; k++) send_item(OpSetReload, k[SlotW-1:0], ticks);
      for (k = 0; k < MtdmNumSlots; k++) send_item(OpStart, k[SlotW-1:0], $urandom);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        k = $urandom_range(0, MtdmNumSlots - 1);
        send_item(OpSetReload, k[SlotW-1:0], pick_ticks());
        send_item(OpStart, k[SlotW-1:0], $urandom);
      end
    end
    repeat ($urandom_range(1, 5)) begin
      send_item(OpElapse, SlotW'($urandom_range(0, 7)), $urandom);
      if ($urandom_range(0, 2) == 0) begin
        send_item(OpRead, SlotW'($urandom_range(0, 7)), $urandom);
      end
    end
    if ($urandom_range(0, 3) == 0) send_item(OpStop, SlotW'($urandom_range(0, 7)), $urandom);
  endtask

  // Stray traffic, unknown operation codes included.
  task automatic send_noise_item();
    logic [OpW-1:0] op;
    op = OpW'($urandom_range(0, 7));
    send_item(op, SlotW'($urandom_range(0, 7)),
              (op == OpSetReload) ? pick_ticks() : $urandom);
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle list, unknown codes, all-ones and zero reloads, joint expiry.
    send_item(OpElapse, 3'd0, '0);
    send_item(OpRead, 3'd7, 32'hFFFF_FFFF);
    send_item(OpStart, 3'd0, '0);
    send_item(3'd5, 3'd5, 32'hFFFF_FFFF);
    send_item(3'd6, 3'd2, '0);
    send_item(3'd7, 3'd7, 32'hA5A5_A5A5);
    send_item(OpSetReload, 3'd0, 32'hFFFF_FFFF);
    send_item(OpStart, 3'd0, '0);
    send_item(OpSetReload, 3'd7, 32'd1);
    send_item(OpStart, 3'd7, '0);
    send_item(OpSetReload, 3'd3, 32'd5);
    send_item(OpStart, 3'd3, '0);
    send_item(OpElapse, 3'd7, '0);
    send_item(OpRead, 3'd0, '0);
    send_item(OpSetReload, 3'd5, 32'd4);
    send_item(OpStart, 3'd5, '0);
    send_item(OpElapse, 3'd0, '0);
    send_item(OpStop, 3'd0, '0);
    send_item(OpElapse, 3'd0, '0);
    send_item(OpRead, 3'd3, '0);
    send_item(OpSetReload, 3'd2, '0);
    send_item(OpStart, 3'd2, '0);
    send_item(OpStop, 3'd4, '0);
    send_item(OpSetReload, 3'd1, 32'd7);
    send_item(OpStart, 3'd1, '0);

    // The sender pauses until every result has come back.
    wait_until_drained();

    // Long receiver hold-off while items keep coming, so the block fills and stalls.
    rx_hold_go <= 1'b1;
    repeat (4) run_timer_burst();

    // Random traffic through the idling phases.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      while (items_sent < 50 + (phase + 1) * PhaseItems) begin
        if ($urandom_range(0, 3) == 0) send_noise_item();
        else run_timer_burst();
      end
    end

    wait_until_drained();
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("multi_timeout_delta_manager_unit_tb: clean");
    end else begin
      $display("multi_timeout_delta_manager_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mtdm_pkg.sv
design/mtdm_ctrl.sv
design/mtdm_datapath.sv
design/multi_timeout_delta_manager_unit.sv
design/mtdm_checker.sv
verif/mtdm_timeout_checker.sv
verif/multi_timeout_delta_manager_unit_tb.sv
